>>> hw/rtl/toyvm_pkg.sv
// toyvm_pkg: shared widths, opcode and status codes for the toy vm executor
// no dependencies; imported by toy_vm_instruction_executor_top
`default_nettype none

package toyvm_pkg;

    // field widths fixed by the instruction format
    localparam int INSTR_W  = 32;
    localparam int VAL_W    = 19;
    localparam int MADDR_W  = 15;
    localparam int RIDX_W   = 3;
    localparam int ST_W     = 3;
    localparam int OP_W     = 4;

    // opcodes
    localparam logic [OP_W-1:0] OP_LDI  = 4'd0;
    localparam logic [OP_W-1:0] OP_ST   = 4'd7;
    localparam logic [OP_W-1:0] OP_BREV = 4'd12;
    localparam logic [OP_W-1:0] OP_LDM  = 4'd15;

    // result status codes
    typedef enum logic [ST_W-1:0] {
        ST_OK        = 3'd0,
        ST_MEM_EMPTY = 3'd1,
        ST_REG_EMPTY = 3'd2,
        ST_BAD_OP    = 3'd3,
        ST_HALTED    = 3'd4
    } status_t;

endpackage

`default_nettype wire

>>> hw/rtl/toy_vm_instruction_executor_top.sv
// toy_vm_instruction_executor_top: executes one instruction word per item
// depends on toyvm_pkg (widths, opcodes, status codes)
//
//  channel | handshake            | payload
//  --------+----------------------+--------------------------------------------
//  in      | in_valid / in_ready  | instr_word
//  out     | out_valid / out_ready| status, reg_written, reg_index, reg_value,
//          |                      | mem_written, mem_addr, mem_value
//
// each word is accepted in S_IDLE, where the accept cycle reads the register file and
// issues the data memory read; in S_EXEC valid bits are checked and the word commits.
// the single-port-read synchronous data memory, with its registered read, sets this split.
// after reset a clearing pass over all 2**MEM_ADDR_BITS addresses zeroes the memory
// valid bits; in_ready stays low meanwhile.
// a word whose result cannot be handed over waits in the commit cycle until
// the output register frees up; no state changes before that.
`default_nettype none

module toy_vm_instruction_executor_top #(
    parameter int MEM_ADDR_BITS = 15,
    parameter int NUM_REGS      = 8
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [toyvm_pkg::INSTR_W-1:0] instr_word,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [toyvm_pkg::ST_W-1:0]         status,
    output logic                               reg_written,
    output logic [toyvm_pkg::RIDX_W-1:0]       reg_index,
    output logic [toyvm_pkg::VAL_W-1:0]        reg_value,
    output logic                               mem_written,
    output logic [toyvm_pkg::MADDR_W-1:0]      mem_addr,
    output logic [toyvm_pkg::VAL_W-1:0]        mem_value
);
    import toyvm_pkg::*;

    localparam int REG_IDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int MEM_DEPTH_N = 1 << MEM_ADDR_BITS;
    localparam logic [VAL_W:0] MEM_LIMIT = {{VAL_W{1'b0}}, 1'b1} << MEM_ADDR_BITS;
    localparam logic [RIDX_W:0] REG_LIMIT = (RIDX_W+1)'(NUM_REGS);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } state_t;

    // data memory: bit VAL_W is the written flag, low bits the value
    logic [VAL_W:0] mem_array [MEM_DEPTH_N];
    logic [VAL_W:0] mem_rdata_reg;
    logic           mem_we;
    logic [MEM_ADDR_BITS-1:0] mem_waddr;
    logic [VAL_W:0] mem_wdata;
    logic           mem_re;
    logic [MEM_ADDR_BITS-1:0] mem_raddr;

    // register file in flops
    logic [VAL_W-1:0] reg_file_reg [NUM_REGS];
    logic [NUM_REGS-1:0] reg_valid_reg, reg_valid_next;

    state_t state_reg, state_next;
    logic [MEM_ADDR_BITS-1:0] clr_cnt_reg, clr_cnt_next;
    logic halted_reg, halted_next;
    logic [INSTR_W-1:0] instr_reg;

    // output register
    logic               out_valid_reg, out_valid_next;
    status_t            status_reg, status_next;
    logic               reg_written_reg, reg_written_next;
    logic [RIDX_W-1:0]  reg_index_reg, reg_index_next;
    logic [VAL_W-1:0]   reg_value_reg, reg_value_next;
    logic               mem_written_reg, mem_written_next;
    logic [MADDR_W-1:0] mem_addr_reg, mem_addr_next;
    logic [VAL_W-1:0]   mem_value_reg, mem_value_next;

    // result of the word in the commit cycle
    status_t            res_status;
    logic               res_reg_we;
    logic [RIDX_W-1:0]  res_reg_idx;
    logic [VAL_W-1:0]   res_reg_val;
    logic               res_mem_we;
    logic [MADDR_W-1:0] res_mem_addr;
    logic [VAL_W-1:0]   res_mem_val;

    logic accept;
    logic commit;
    logic out_free;
    logic [VAL_W-1:0] rd_addr_full;

    function automatic logic reg_in_range(input logic [RIDX_W-1:0] r);
        return {1'b0, r} < REG_LIMIT;
    endfunction

    function automatic logic mem_in_range(input logic [VAL_W-1:0] a);
        return {1'b0, a} < MEM_LIMIT;
    endfunction

    function automatic logic [REG_IDX_W-1:0] reg_sel(input logic [RIDX_W-1:0] r);
        return r[REG_IDX_W-1:0];
    endfunction

    function automatic logic [MEM_ADDR_BITS-1:0] mem_addr_trim(
        input logic [MADDR_W-1:0] a);
        logic [VAL_W-1:0] ext;
        ext = VAL_W'(a);
        return ext[MEM_ADDR_BITS-1:0];
    endfunction

    // handshake
    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign commit   = (state_reg == S_EXEC) && out_free;

    // read address: load uses the field, bit reverse uses register c
    always_comb
    begin
        logic [RIDX_W-1:0] c_in;
        c_in = instr_word[9:7];
        if (instr_word[3:0] == OP_BREV)
        begin
            if (reg_in_range(c_in))
                rd_addr_full = reg_file_reg[reg_sel(c_in)];
            else
                rd_addr_full = '0;
        end
        else
        begin
            rd_addr_full = VAL_W'(instr_word[21:7]);
        end
    end

    assign mem_re    = accept;
    assign mem_raddr = rd_addr_full[MEM_ADDR_BITS-1:0];

    // execute the held word against the read data
    always_comb
    begin
        logic [RIDX_W-1:0]  b_f;
        logic [RIDX_W-1:0]  c_f;
        logic [VAL_W-1:0]   a_f;
        logic [VAL_W-1:0]   m_f;
        b_f = instr_reg[6:4];
        c_f = '0;
        a_f = '0;
        m_f = mem_rdata_reg[VAL_W-1:0];
        res_status   = ST_OK;
        res_reg_we   = 1'b0;
        res_reg_idx  = '0;
        res_reg_val  = '0;
        res_mem_we   = 1'b0;
        res_mem_addr = '0;
        res_mem_val  = '0;
        if (halted_reg)
        begin
            res_status = ST_HALTED;
        end
        else
        begin
            case (instr_reg[3:0])
                OP_LDI:
                begin
                    if (reg_in_range(instr_reg[25:23]))
                    begin
                        res_reg_we  = 1'b1;
                        res_reg_idx = instr_reg[25:23];
                        res_reg_val = instr_reg[22:4];
                    end
                end
                OP_LDM:
                begin
                    a_f = VAL_W'(instr_reg[21:7]);
                    if (!mem_in_range(a_f) || !mem_rdata_reg[VAL_W])
                        res_status = ST_MEM_EMPTY;
                    else if (reg_in_range(b_f))
                    begin
                        res_reg_we  = 1'b1;
                        res_reg_idx = b_f;
                        res_reg_val = m_f;
                    end
                end
                OP_ST:
                begin
                    c_f = instr_reg[21:19];
                    a_f = VAL_W'(instr_reg[18:4]);
                    if (!reg_in_range(c_f) || !reg_valid_reg[reg_sel(c_f)])
                        res_status = ST_REG_EMPTY;
                    else if (mem_in_range(a_f))
                    begin
                        res_mem_we   = 1'b1;
                        res_mem_addr = instr_reg[18:4];
                        res_mem_val  = reg_file_reg[reg_sel(c_f)];
                    end
                end
                OP_BREV:
                begin
                    c_f = instr_reg[9:7];
                    if (!reg_in_range(c_f) || !reg_valid_reg[reg_sel(c_f)])
                        res_status = ST_REG_EMPTY;
                    else
                    begin
                        a_f = reg_file_reg[reg_sel(c_f)];
                        if (!mem_in_range(a_f) || !mem_rdata_reg[VAL_W])
                            res_status = ST_MEM_EMPTY;
                        else if (reg_in_range(b_f))
                        begin
                            res_reg_we  = 1'b1;
                            res_reg_idx = b_f;
                            res_reg_val = VAL_W'({m_f[0], m_f[1], m_f[2]});
                        end
                    end
                end
                default:
                begin
                    res_status = ST_BAD_OP;
                end
            endcase
        end
    end

    // memory write port: clearing pass or store commit
    always_comb
    begin
        if (state_reg == S_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = commit && res_mem_we;
            mem_waddr = mem_addr_trim(res_mem_addr);
            mem_wdata = {1'b1, res_mem_val};
        end
    end

    // next state and output register
    always_comb
    begin
        state_next       = state_reg;
        clr_cnt_next     = clr_cnt_reg;
        halted_next      = halted_reg;
        reg_valid_next   = reg_valid_reg;
        out_valid_next   = out_valid_reg;
        status_next      = status_reg;
        reg_written_next = reg_written_reg;
        reg_index_next   = reg_index_reg;
        reg_value_next   = reg_value_reg;
        mem_written_next = mem_written_reg;
        mem_addr_next    = mem_addr_reg;
        mem_value_next   = mem_value_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (&clr_cnt_reg)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (accept)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (commit)
                begin
                    state_next       = S_IDLE;
                    out_valid_next   = 1'b1;
                    status_next      = res_status;
                    reg_written_next = res_reg_we;
                    reg_index_next   = res_reg_idx;
                    reg_value_next   = res_reg_val;
                    mem_written_next = res_mem_we;
                    mem_addr_next    = res_mem_addr;
                    mem_value_next   = res_mem_val;
                    if (res_reg_we)
                        reg_valid_next[reg_sel(res_reg_idx)] = 1'b1;
                    if (res_status != ST_OK)
                        halted_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // control state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            clr_cnt_reg     <= '0;
            halted_reg      <= 1'b0;
            reg_valid_reg   <= '0;
            out_valid_reg   <= 1'b0;
            status_reg      <= ST_OK;
            reg_written_reg <= 1'b0;
            reg_index_reg   <= '0;
            reg_value_reg   <= '0;
            mem_written_reg <= 1'b0;
            mem_addr_reg    <= '0;
            mem_value_reg   <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            clr_cnt_reg     <= clr_cnt_next;
            halted_reg      <= halted_next;
            reg_valid_reg   <= reg_valid_next;
            out_valid_reg   <= out_valid_next;
            status_reg      <= status_next;
            reg_written_reg <= reg_written_next;
            reg_index_reg   <= reg_index_next;
            reg_value_reg   <= reg_value_next;
            mem_written_reg <= mem_written_next;
            mem_addr_reg    <= mem_addr_next;
            mem_value_reg   <= mem_value_next;
        end
    end

    // held word and register file contents
    always_ff @(posedge clk)
    begin
        if (accept)
            instr_reg <= instr_word;
        if (commit && res_reg_we)
            reg_file_reg[reg_sel(res_reg_idx)] <= res_reg_val;
    end

    // data memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem_array[mem_waddr] <= mem_wdata;
        if (mem_re)
            mem_rdata_reg <= mem_array[mem_raddr];
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign reg_written = reg_written_reg;
    assign reg_index   = reg_index_reg;
    assign reg_value   = reg_value_reg;
    assign mem_written = mem_written_reg;
    assign mem_addr    = mem_addr_reg;
    assign mem_value   = mem_value_reg;

    // halt is sticky until reset
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> halted_reg)
        else $error("halt flag cleared without reset");

    // an accepted word is in the execute state in the following cycle
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_EXEC)
        else $error("accepted word not executed");

    // failed or halted words report no register or memory write
    a_err_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg != ST_OK) |-> (!reg_written_reg && !mem_written_reg))
        else $error("error word reports a write");

    // a word writes a register or memory, never both
    a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(reg_written_reg && mem_written_reg))
        else $error("word reports two writes");

endmodule

`default_nettype wire
